### hw/rtl/ill_pkg.sv
// Shared types and codes for the integer literal lexer.
// Used by the front classifier, the queue, the back sequencer and the top level.
// No dependencies.
package ill_pkg;

    // result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_LEADZERO = 3'd1;
    localparam logic [2:0] ST_NODIGITS = 3'd2;
    localparam logic [2:0] ST_INVALID  = 3'd3;
    localparam logic [2:0] ST_OVERFLOW = 3'd4;

    // base codes
    localparam logic [1:0] BASE_DEC = 2'd0;
    localparam logic [1:0] BASE_BIN = 2'd1;
    localparam logic [1:0] BASE_OCT = 2'd2;
    localparam logic [1:0] BASE_HEX = 2'd3;

    localparam int unsigned VALUE_W = 64;

    // depth of the queue between front and back, and the width of its fill count
    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

    // one classified character, as it travels from front to back
    typedef struct packed {
        logic [3:0] digit;     // digit value when is_hex is set
        logic       is_hex;    // 0-9, a-f, A-F
        logic       is_letter; // ASCII letter
        logic       is_pfx;    // b, B, o, O, x, X
        logic [1:0] pfx_code;  // base code chosen by the prefix
    } cls_t;

    // one result item
    typedef struct packed {
        logic               consumed;
        logic [4:0]         radix;
        logic [2:0]         status;
        logic [VALUE_W-1:0] value;
    } res_t;

    // queue status seen by the top level
    typedef struct packed {
        logic               full;
        logic               empty;
        logic [Q_CNT_W-1:0] count;
    } q_stat_t;

    function automatic logic [4:0] radix_of(input logic [1:0] code);
        logic [4:0] r;
        unique case (code)
            BASE_DEC: r = 5'd10;
            BASE_BIN: r = 5'd2;
            BASE_OCT: r = 5'd8;
            BASE_HEX: r = 5'd16;
            default:  r = 5'd10;
        endcase
        return r;
    endfunction

endpackage

### hw/rtl/ill_front.sv
// Front classifier of the integer literal lexer: turns a character byte into
// digit value and character class flags. Depends on ill_pkg.
module ill_front
    import ill_pkg::*;
(
    input  logic [7:0] ch,
    output cls_t       cls
);

    localparam logic [7:0] CH_0  = 8'h30;
    localparam logic [7:0] CH_9  = 8'h39;
    localparam logic [7:0] CH_UA = 8'h41;
    localparam logic [7:0] CH_UF = 8'h46;
    localparam logic [7:0] CH_UZ = 8'h5A;
    localparam logic [7:0] CH_LA = 8'h61;
    localparam logic [7:0] CH_LF = 8'h66;
    localparam logic [7:0] CH_LZ = 8'h7A;
    localparam logic [7:0] CH_UB = 8'h42;
    localparam logic [7:0] CH_LB = 8'h62;
    localparam logic [7:0] CH_UO = 8'h4F;
    localparam logic [7:0] CH_LO = 8'h6F;
    localparam logic [7:0] CH_UX = 8'h58;
    localparam logic [7:0] CH_LX = 8'h78;
    localparam logic [7:0] OFS_LOWER = 8'h57; // 'a' - 10
    localparam logic [7:0] OFS_UPPER = 8'h37; // 'A' - 10

    logic       is_dec;
    logic       is_lhex;
    logic       is_uhex;
    logic [7:0] dig_full;

    // find the digit value in each of the three ranges
    always_comb
    begin
        is_dec  = (ch >= CH_0) && (ch <= CH_9);
        is_lhex = (ch >= CH_LA) && (ch <= CH_LF);
        is_uhex = (ch >= CH_UA) && (ch <= CH_UF);
        priority if (is_dec)
            dig_full = ch - CH_0;
        else if (is_lhex)
            dig_full = ch - OFS_LOWER;
        else if (is_uhex)
            dig_full = ch - OFS_UPPER;
        else
            dig_full = 8'd0;
    end

    // build the class flags and the prefix code
    always_comb
    begin
        cls.digit     = dig_full[3:0];
        cls.is_hex    = is_dec || is_lhex || is_uhex;
        cls.is_letter = ((ch >= CH_LA) && (ch <= CH_LZ)) || ((ch >= CH_UA) && (ch <= CH_UZ));
        cls.is_pfx    = (ch == CH_LB) || (ch == CH_UB) || (ch == CH_LO) || (ch == CH_UO)
                     || (ch == CH_LX) || (ch == CH_UX);
        priority if ((ch == CH_LB) || (ch == CH_UB))
            cls.pfx_code = BASE_BIN;
        else if ((ch == CH_LO) || (ch == CH_UO))
            cls.pfx_code = BASE_OCT;
        else if ((ch == CH_LX) || (ch == CH_UX))
            cls.pfx_code = BASE_HEX;
        else
            cls.pfx_code = BASE_DEC;
    end

endmodule

### hw/rtl/ill_queue.sv
// Two-entry queue of classified characters between front and back.
// Depends on ill_pkg.
module ill_queue
    import ill_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  cls_t    in_cls,
    output logic    out_valid,
    input  logic    out_ready,
    output cls_t    out_cls,
    output q_stat_t stat
);

    localparam int unsigned PTR_W   = $clog2(Q_DEPTH);
    localparam int unsigned CNT_W   = Q_CNT_W;

    cls_t             entries_reg [Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign in_ready  = (count_reg != CNT_W'(Q_DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_cls   = entries_reg[rd_ptr_reg];

    assign stat.full  = !in_ready;
    assign stat.empty = !out_valid;
    assign stat.count = count_reg;

    // advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // store the incoming beat
    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= in_cls;
    end

endmodule

### hw/rtl/ill_back.sv
// Back sequencer of the integer literal lexer: runs the literal state machine,
// accumulates digits with overflow tracking and holds the result register.
// Depends on ill_pkg.
module ill_back
    import ill_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  cls_t in_cls,
    output logic out_valid,
    input  logic out_ready,
    output res_t out_res
);

    typedef enum logic [2:0] {
        PH_IDLE   = 3'b001,
        PH_ZERO   = 3'b010,
        PH_DIGITS = 3'b100
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [1:0]         base_reg, base_next;
    logic [VALUE_W-1:0] accum_reg, accum_next;
    logic               ovf_reg, ovf_next;
    logic               have_reg, have_next;
    logic               res_valid_reg, res_valid_next;
    res_t               res_reg, res_next;

    logic               take;
    logic               emit;
    res_t               emit_res;
    logic               digit_ok;
    logic [VALUE_W+3:0] scaled;
    logic [VALUE_W+3:0] sum;
    logic [4:0]         radix;

    // take a beat when the result slot is free or drains this cycle
    assign in_ready  = !res_valid_reg || out_ready;
    assign take      = in_valid && in_ready;
    assign out_valid = res_valid_reg;
    assign out_res   = res_reg;
    assign radix     = radix_of(base_reg);

    // check the digit against the current base
    always_comb
    begin
        unique case (base_reg)
            BASE_DEC: digit_ok = in_cls.is_hex && (in_cls.digit < 4'd10);
            BASE_BIN: digit_ok = in_cls.is_hex && (in_cls.digit < 4'd2);
            BASE_OCT: digit_ok = in_cls.is_hex && (in_cls.digit < 4'd8);
            BASE_HEX: digit_ok = in_cls.is_hex;
            default:  digit_ok = 1'b0;
        endcase
    end

    // scale by the radix with shifts, then add the digit; high bits flag overflow
    always_comb
    begin
        unique case (base_reg)
            BASE_DEC: scaled = ({4'd0, accum_reg} << 3) + ({4'd0, accum_reg} << 1);
            BASE_BIN: scaled = {4'd0, accum_reg} << 1;
            BASE_OCT: scaled = {4'd0, accum_reg} << 3;
            BASE_HEX: scaled = {4'd0, accum_reg} << 4;
            default:  scaled = '0;
        endcase
        sum = scaled + {{(VALUE_W){1'b0}}, in_cls.digit};
    end

    // literal state machine
    always_comb
    begin
        phase_next = phase_reg;
        base_next  = base_reg;
        accum_next = accum_reg;
        ovf_next   = ovf_reg;
        have_next  = have_reg;
        emit       = 1'b0;
        emit_res   = '{consumed: 1'b1, radix: 5'd10, status: ST_INVALID, value: '0};
        if (take)
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    priority if (in_cls.is_hex && (in_cls.digit == 4'd0))
                        phase_next = PH_ZERO;
                    else if (in_cls.is_hex && (in_cls.digit < 4'd10))
                    begin
                        base_next  = BASE_DEC;
                        accum_next = VALUE_W'(in_cls.digit);
                        have_next  = 1'b1;
                        phase_next = PH_DIGITS;
                    end
                    else
                        emit = 1'b1;
                end
                PH_ZERO:
                begin
                    priority if (in_cls.is_hex && (in_cls.digit == 4'd0))
                    begin
                        emit            = 1'b1;
                        emit_res.status = ST_LEADZERO;
                    end
                    else if (in_cls.is_pfx)
                    begin
                        base_next  = in_cls.pfx_code;
                        accum_next = '0;
                        have_next  = 1'b0;
                        phase_next = PH_DIGITS;
                    end
                    else if (!in_cls.is_letter)
                    begin
                        emit              = 1'b1;
                        emit_res.status   = ST_OK;
                        emit_res.consumed = 1'b0;
                    end
                    else
                        emit = 1'b1;
                end
                PH_DIGITS:
                begin
                    if (digit_ok)
                    begin
                        if (!ovf_reg)
                        begin
                            if (sum[VALUE_W+3:VALUE_W] != 4'd0)
                                ovf_next = 1'b1;
                            else
                                accum_next = sum[VALUE_W-1:0];
                        end
                        have_next = 1'b1;
                    end
                    else
                    begin
                        emit              = 1'b1;
                        emit_res.consumed = 1'b0;
                        emit_res.radix    = radix;
                        priority if (!have_reg)
                            emit_res.status = ST_NODIGITS;
                        else if (ovf_reg)
                            emit_res.status = ST_OVERFLOW;
                        else
                        begin
                            emit_res.status = ST_OK;
                            emit_res.value  = accum_reg;
                        end
                    end
                end
                default: ;
            endcase
            // return to idle after any result
            if (emit)
            begin
                phase_next = PH_IDLE;
                base_next  = BASE_DEC;
                accum_next = '0;
                ovf_next   = 1'b0;
                have_next  = 1'b0;
            end
        end
    end

    // load or drain the result register
    always_comb
    begin
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        if (res_valid_reg && out_ready)
            res_valid_next = 1'b0;
        if (emit)
        begin
            res_next       = emit_res;
            res_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            base_reg      <= BASE_DEC;
            accum_reg     <= '0;
            ovf_reg       <= 1'b0;
            have_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            base_reg      <= base_next;
            accum_reg     <= accum_next;
            ovf_reg       <= ovf_next;
            have_reg      <= have_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // hold result payload
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

endmodule

### hw/rtl/integer_literal_lexer_unit.sv
// Top level of the integer literal lexer: front classifier, two-entry queue,
// back sequencer with result register. Depends on ill_pkg and the ill_* modules.
//
//  channel | dir | handshake          | tdata fields (lsb first)
//  --------+-----+--------------------+-----------------------------------------------
//  s_axis  | in  | s_tvalid/s_tready  | ch[7:0]
//  m_axis  | out | m_tvalid/m_tready  | value[63:0] status[66:64] radix[71:67]
//          |     |                    | consumed[72], zero fill [79:73]
//
// One character per cycle sustained while m_tready stays high; a result leaves
// the back sequencer in the cycle after the terminating character is taken from
// the queue, and the 64-bit accumulate with overflow check sets the clock period.
// Reset (rst_n low, asynchronous) empties the queue and the result register
// and returns the lexer to idle. A stalled m_tready fills the result register,
// then the queue; s_tready drops only when the queue is full.
module integer_literal_lexer_unit
    import ill_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,  // ch[7:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata   // value, status, radix, consumed, zero fill
);

    cls_t    front_cls;
    cls_t    q_cls;
    logic    q_valid;
    logic    back_ready;
    q_stat_t q_stat;
    res_t    res;

    ill_front u_front (
        .ch  (s_tdata),
        .cls (front_cls)
    );

    ill_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cls    (front_cls),
        .out_valid (q_valid),
        .out_ready (back_ready),
        .out_cls   (q_cls),
        .stat      (q_stat)
    );

    ill_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_valid),
        .in_ready  (back_ready),
        .in_cls    (q_cls),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    // pack the result beat
    assign m_tdata = {7'd0, res.consumed, res.radix, res.status, res.value};

    // an error result never carries a value
    a_err_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (res.status != ST_OK) |-> (res.value == '0))
        else $error("error result with nonzero value");

    // a terminator left for re-lexing comes only with ok, no digits or overflow
    a_unconsumed_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !res.consumed |->
            (res.status == ST_OK) || (res.status == ST_NODIGITS) || (res.status == ST_OVERFLOW))
        else $error("unconsumed terminator with wrong status");

    // input stalls only when the queue is full, and the count stays in range
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tready == !q_stat.full) && (q_stat.count <= Q_CNT_W'(Q_DEPTH))
            && !(q_stat.full && q_stat.empty))
        else $error("queue status inconsistent");

    // queue drains while the result register is free
    a_back_drains: assert property (@(posedge clk) disable iff (!rst_n)
        !q_stat.empty && !m_tvalid |-> back_ready)
        else $error("back stalls with free result register");

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for integer_literal_lexer_unit: streams characters in,
// predicts each lexed literal and compares every result beat field by field.
// Depends on ill_pkg and the lexer RTL.
module tb_top;
    import ill_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT    = 400000;
    localparam int unsigned RANDOM_ITEMS   = 450;
    localparam int unsigned LONG_HOLD      = 80;
    localparam int unsigned DRAIN_CYCLES   = 8;

    typedef enum logic [2:0] {
        LX_IDLE   = 3'b001,
        LX_ZERO   = 3'b010,
        LX_DIGITS = 3'b100
    } lex_phase_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // ch[7:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;   // value[63:0] status[66:64] radix[71:67] consumed[72]

    // lexer state mirrored by the predictor
    lex_phase_t  lex_phase;
    logic [1:0]  lex_base;
    logic [63:0] lex_accum;
    logic        lex_ovf;
    logic        lex_seen_digit;

    res_t        pending_tokens[$];
    int unsigned mismatch_count;
    int unsigned items_sent;
    int unsigned burst_left;
    bit          no_gaps;
    bit          hold_req;
    int unsigned hold_left;
    int unsigned ready_step;
    int unsigned cycle_count;

    integer_literal_lexer_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock, 10 ns period
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------
    // Lexer predictor
    // ------------------------------------------------------------------

    // value of a hex digit, 16 for anything else
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return 5'(c - "0");
        if (c >= "a" && c <= "f")
            return 5'(c - "a" + 8'd10);
        if (c >= "A" && c <= "F")
            return 5'(c - "A" + 8'd10);
        return 5'd16;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        logic [7:0] low;
        low = c | 8'h20;
        return (low >= "a") && (low <= "z");
    endfunction

    function automatic logic [4:0] base_radix(input logic [1:0] code);
        return (code == BASE_BIN) ? 5'd2 :
               (code == BASE_OCT) ? 5'd8 :
               (code == BASE_HEX) ? 5'd16 : 5'd10;
    endfunction

    // build the result beat and return the lexer to idle
    function automatic res_t close_literal(input logic [2:0] status, input logic [4:0] rdx,
                                           input logic used);
        res_t tok;
        tok.value    = (status == ST_OK) ? lex_accum : 64'd0;
        tok.status   = status;
        tok.radix    = rdx;
        tok.consumed = used;
        lex_phase      = LX_IDLE;
        lex_base       = BASE_DEC;
        lex_accum      = 64'd0;
        lex_ovf        = 1'b0;
        lex_seen_digit = 1'b0;
        return tok;
    endfunction

    function automatic void lex_char(input logic [7:0] c, output logic fire,
                                     output res_t tok);
        logic [4:0]  dig;
        logic [4:0]  rdx;
        logic [71:0] wide;
        fire = 1'b0;
        tok  = '0;
        dig  = hex_digit(c);
        case (lex_phase)
            LX_IDLE:
            begin
                if (c == "0")
                    lex_phase = LX_ZERO;
                else if (c >= "1" && c <= "9")
                begin
                    lex_base       = BASE_DEC;
                    lex_accum      = 64'(dig);
                    lex_seen_digit = 1'b1;
                    lex_phase      = LX_DIGITS;
                end
                else
                begin
                    fire = 1'b1;
                    tok  = close_literal(ST_INVALID, 5'd10, 1'b1);
                end
            end
            LX_ZERO:
            begin
                if (c == "0")
                begin
                    fire = 1'b1;
                    tok  = close_literal(ST_LEADZERO, 5'd10, 1'b1);
                end
                else if (c == "b" || c == "B" || c == "o" || c == "O" ||
                         c == "x" || c == "X")
                begin
                    lex_base = (c == "b" || c == "B") ? BASE_BIN :
                               (c == "o" || c == "O") ? BASE_OCT : BASE_HEX;
                    lex_accum      = 64'd0;
                    lex_seen_digit = 1'b0;
                    lex_phase      = LX_DIGITS;
                end
                else if (!is_alpha(c))
                begin
                    // lone zero, terminator goes back to the caller
                    fire = 1'b1;
                    tok  = close_literal(ST_OK, 5'd10, 1'b0);
                end
                else
                begin
                    fire = 1'b1;
                    tok  = close_literal(ST_INVALID, 5'd10, 1'b1);
                end
            end
            default:
            begin
                rdx = base_radix(lex_base);
                if (dig < rdx)
                begin
                    // accumulate; the flag freezes the value once set
                    if (!lex_ovf)
                    begin
                        wide = {8'd0, lex_accum} * 72'(rdx) + 72'(dig);
                        if (wide[71:64] != 8'd0)
                            lex_ovf = 1'b1;
                        else
                            lex_accum = wide[63:0];
                    end
                    lex_seen_digit = 1'b1;
                end
                else
                begin
                    fire = 1'b1;
                    if (!lex_seen_digit)
                        tok = close_literal(ST_NODIGITS, rdx, 1'b0);
                    else if (lex_ovf)
                        tok = close_literal(ST_OVERFLOW, rdx, 1'b0);
                    else
                        tok = close_literal(ST_OK, rdx, 1'b0);
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // offer one character, wait for the beat, then predict
    task automatic send_char(input logic [7:0] c);
        logic fire;
        res_t tok;
        int unsigned gap;
        if (!no_gaps && burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        lex_char(c, fire, tok);
        if (fire)
            pending_tokens.push_back(tok);
        items_sent++;
        if (burst_left != 0)
            burst_left--;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    function automatic logic [7:0] pick_terminator();
        case ($urandom_range(0, 6))
            0:       return " ";
            1:       return ",";
            2:       return ")";
            3:       return 8'h00;
            4:       return 8'($urandom_range("g", "z"));
            5:       return 8'($urandom_range(128, 255));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // prefixed or decimal literal with random digits, sometimes near 2^64
    task automatic send_random_literal();
        int unsigned base_sel;
        int unsigned ndig;
        int unsigned d;
        int unsigned dmax;
        bit          near_limit;
        bit          all_max;
        near_limit = ($urandom_range(0, 9) == 0);
        all_max    = near_limit && ($urandom_range(0, 1) == 1);
        base_sel   = $urandom_range(0, 3);
        case (base_sel)
            0:
            begin
                ndig = near_limit ? $urandom_range(19, 21) : $urandom_range(1, 6);
                dmax = 9;
            end
            1:
            begin
                ndig = near_limit ? $urandom_range(63, 65) : $urandom_range(0, 10);
                dmax = 1;
                send_char("0");
                send_char($urandom_range(0, 1) ? "b" : "B");
            end
            2:
            begin
                ndig = near_limit ? $urandom_range(21, 23) : $urandom_range(0, 6);
                dmax = 7;
                send_char("0");
                send_char($urandom_range(0, 1) ? "o" : "O");
            end
            default:
            begin
                ndig = near_limit ? $urandom_range(15, 17) : $urandom_range(0, 6);
                dmax = 15;
                send_char("0");
                send_char($urandom_range(0, 1) ? "x" : "X");
            end
        endcase
        for (int i = 0; i < ndig; i++)
        begin
            d = all_max ? dmax : $urandom_range(0, dmax);
            // decimal literals never start with 0
            if (base_sel == 0 && i == 0)
                d = near_limit ? 1 : $urandom_range(1, 9);
            if (d < 10)
                send_char(8'("0" + d));
            else
                send_char(8'(($urandom_range(0, 1) ? "A" : "a") + d - 10));
        end
        send_char(pick_terminator());
    endtask

    // stray bytes and broken literals
    task automatic send_noise();
        case ($urandom_range(0, 3))
            0:
            begin
                repeat ($urandom_range(1, 3))
                    send_char(8'($urandom_range(0, 255)));
            end
            1:
            begin
                send_char("0");
                send_char(8'($urandom_range(0, 255)));
            end
            2:
            begin
                send_char("0");
                send_char("0");
            end
            default:
            begin
                send_char("0");
                send_char("x");
                send_char(pick_terminator());
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Receiver: own stall pattern plus an optional long hold-off
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left != 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = LONG_HOLD;
            m_tready <= 1'b0;
        end
        else
        begin
            case (ready_step[6:5])
                2'd0:    m_tready <= 1'b1;
                2'd1:    m_tready <= 1'($urandom_range(0, 1));
                2'd2:    m_tready <= (ready_step[1:0] != 2'd0);
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
        ready_step++;
    end

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [63:0] exp_val,
                                        input logic [63:0] act_val);
        if (exp_val !== act_val)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $realtime, name, exp_val, act_val);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_tokens.size() == 0)
            begin
                $display("%0t: result beat with nothing expected, actual %0h",
                         $realtime, m_tdata);
                mismatch_count++;
            end
            else
            begin
                want = pending_tokens.pop_front();
                check_field("value", want.value, m_tdata[63:0]);
                check_field("status", 64'(want.status), 64'(m_tdata[66:64]));
                check_field("radix", 64'(want.radix), 64'(m_tdata[71:67]));
                check_field("consumed", 64'(want.consumed), 64'(m_tdata[72]));
                check_field("fill", 64'd0, 64'(m_tdata[79:73]));
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // extremes of ch and the special cases other than overflow, one after another
    task automatic test_special_cases();
        send_text("0");
        send_char(8'h00);       // lone zero at end of input
        send_text("00");        // second leading zero
        send_text("0b2");       // prefix with no digits
        send_text("0z");        // other letter after zero
        send_char(8'hFF);       // bad first character
        send_char(8'h00);       // end of input in idle
        send_text("12a");       // letter ends a decimal
        send_text("0x1g");      // non-hex letter ends a hex literal
        send_text("0O7");
        send_char(8'hFF);
        send_text("05");        // digit after a lone zero
    endtask

    // mostly well-formed literals, the rest noise
    task automatic test_random_stream();
        int unsigned start;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 99) < 85)
                send_random_literal();
            else
                send_noise();
        end
    endtask

    // hold the output off while characters keep coming, so the input stalls
    task automatic test_output_stall();
        no_gaps  = 1'b1;
        hold_req = 1'b1;
        repeat (20)
        begin
            send_char(8'($urandom_range("1", "9")));
            send_char(" ");
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        s_tvalid       <= 1'b0;
        s_tdata        <= 8'h00;
        mismatch_count  = 0;
        items_sent      = 0;
        burst_left      = 0;
        no_gaps         = 1'b0;
        hold_req        = 1'b0;
        hold_left       = 0;
        ready_step      = 0;
        cycle_count     = 0;
        lex_phase       = LX_IDLE;
        lex_base        = BASE_DEC;
        lex_accum       = 64'd0;
        lex_ovf         = 1'b0;
        lex_seen_digit  = 1'b0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_special_cases();
        test_output_stall();
        test_random_stream();
        s_tvalid <= 1'b0;

        // drain outstanding results, then watch for strays
        while (pending_tokens.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_tokens.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

### integer_literal_lexer_unit.f
hw/rtl/ill_pkg.sv
hw/rtl/ill_front.sv
hw/rtl/ill_queue.sv
hw/rtl/ill_back.sv
hw/rtl/integer_literal_lexer_unit.sv
tb/sv/tb_top.sv
